// ===== rtl/rthsv_pkg.sv =====
// ---------------------------------------------------------------------------
// rthsv_pkg: shared types for the rgb to hsv pixel converter
// Channel width, divider widths and the beat that walks the divider pipeline.
// ---------------------------------------------------------------------------
package rthsv_pkg;

    localparam int COLOR_BITS = 12;
    // 6 * chroma needs three more bits than a channel
    localparam int HUE_W      = COLOR_BITS + 3;

    typedef logic [COLOR_BITS-1:0] t_chan;
    typedef logic [HUE_W-1:0]      t_hdiv;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } t_maxsel;

    // one beat of both restoring dividers; the quotient shifts in where
    // the low dividend bits shift out
    typedef struct packed {
        logic  valid;
        t_chan s_rem;
        t_chan s_quo;
        t_chan s_div;
        t_hdiv h_rem;
        t_chan h_quo;
        t_hdiv h_div;
        t_chan bright;
    } t_div_beat;

endpackage

// ===== rtl/rthsv_div_step.sv =====
// ---------------------------------------------------------------------------
// rthsv_div_step: one quotient bit of the saturation and hue dividers
// Registered restoring step, both dividers side by side, value rides along.
// ---------------------------------------------------------------------------
module rthsv_div_step
    import rthsv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_beat i_beat,
    output t_div_beat o_beat
);

    t_div_beat r_beat;
    t_div_beat n_beat;

    logic [COLOR_BITS:0] s_trial;
    logic [COLOR_BITS:0] s_diff;
    logic                s_ge;
    logic [HUE_W:0]      h_trial;
    logic [HUE_W:0]      h_diff;
    logic                h_ge;

    always_comb begin
        s_trial = {i_beat.s_rem, i_beat.s_quo[COLOR_BITS-1]};
        s_diff  = s_trial - {1'b0, i_beat.s_div};
        s_ge    = (s_trial >= {1'b0, i_beat.s_div});
        h_trial = {i_beat.h_rem, i_beat.h_quo[COLOR_BITS-1]};
        h_diff  = h_trial - {1'b0, i_beat.h_div};
        h_ge    = (h_trial >= {1'b0, i_beat.h_div});

        n_beat       = i_beat;
        n_beat.s_rem = s_ge ? s_diff[COLOR_BITS-1:0] : s_trial[COLOR_BITS-1:0];
        n_beat.s_quo = {i_beat.s_quo[COLOR_BITS-2:0], s_ge};
        n_beat.h_rem = h_ge ? h_diff[HUE_W-1:0] : h_trial[HUE_W-1:0];
        n_beat.h_quo = {i_beat.h_quo[COLOR_BITS-2:0], h_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
        r_beat.s_rem  <= n_beat.s_rem;
        r_beat.s_quo  <= n_beat.s_quo;
        r_beat.s_div  <= n_beat.s_div;
        r_beat.h_rem  <= n_beat.h_rem;
        r_beat.h_quo  <= n_beat.h_quo;
        r_beat.h_div  <= n_beat.h_div;
        r_beat.bright <= n_beat.bright;
    end

    assign o_beat = r_beat;

endmodule

// ===== rtl/rgb_to_hsv_pixel.sv =====
// ---------------------------------------------------------------------------
// rgb_to_hsv_pixel: rgb pixel to hue, saturation and value
// Takes one pixel a clock and returns one hsv result for each, in order.
// ---------------------------------------------------------------------------
// A pixel is taken on every clock where start is high; busy never rises, so
// the converter sustains one pixel per clock. Each result appears on o_hue,
// o_saturation and o_brightness for the one cycle where o_valid is high,
// COLOR_BITS + 2 clocks after the edge that took the pixel (14 at 12 bits),
// and must be captured then. The latency is set by the two restoring
// dividers, which resolve one quotient bit per pipeline stage behind two
// stages that find max, min, chroma and the hue numerator.
module rgb_to_hsv_pixel
    import rthsv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_chan i_red,
    input  t_chan i_green,
    input  t_chan i_blue,
    output logic  o_valid,
    output t_chan o_hue,
    output t_chan o_saturation,
    output t_chan o_brightness
);

    // stage a: captured pixel
    logic    r_a_valid;
    t_chan   r_a_red;
    t_chan   r_a_green;
    t_chan   r_a_blue;

    // stage b: max channel and min found
    logic    r_b_valid;
    t_maxsel r_b_sel;
    t_maxsel n_b_sel;
    t_chan   r_b_max;
    t_chan   n_b_max;
    t_chan   r_b_min;
    t_chan   n_b_min;
    t_chan   r_b_red;
    t_chan   r_b_green;
    t_chan   r_b_blue;

    // stage c: divider operands
    t_chan                 c_chroma;
    t_hdiv                 c_chroma6;
    t_hdiv                 c_num;
    logic [2*COLOR_BITS-1:0] c_sat_dvd;
    t_div_beat             n_c_beat;

    t_div_beat r_c_beat;
    t_div_beat w_beat [COLOR_BITS+1];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= start && !busy;
            r_b_valid <= r_a_valid;
        end
        r_a_red   <= i_red;
        r_a_green <= i_green;
        r_a_blue  <= i_blue;
        r_b_sel   <= n_b_sel;
        r_b_max   <= n_b_max;
        r_b_min   <= n_b_min;
        r_b_red   <= r_a_red;
        r_b_green <= r_a_green;
        r_b_blue  <= r_a_blue;
    end

    // ties go to red, then green
    always_comb begin
        if ((r_a_red >= r_a_green) && (r_a_red >= r_a_blue)) begin
            n_b_sel = MAX_RED;
            n_b_max = r_a_red;
        end else if (r_a_green >= r_a_blue) begin
            n_b_sel = MAX_GREEN;
            n_b_max = r_a_green;
        end else begin
            n_b_sel = MAX_BLUE;
            n_b_max = r_a_blue;
        end
        if ((r_a_red <= r_a_green) && (r_a_red <= r_a_blue)) begin
            n_b_min = r_a_red;
        end else if (r_a_green <= r_a_blue) begin
            n_b_min = r_a_green;
        end else begin
            n_b_min = r_a_blue;
        end
    end

    always_comb begin
        c_chroma  = r_b_max - r_b_min;
        c_chroma6 = {1'b0, c_chroma, 2'b00} + {2'b00, c_chroma, 1'b0};
        // modulo 2^HUE_W arithmetic; the true numerator is below 6 * chroma
        case (r_b_sel)
            MAX_RED: begin
                if (r_b_green >= r_b_blue) begin
                    c_num = {3'b000, r_b_green} - {3'b000, r_b_blue};
                end else begin
                    c_num = c_chroma6 + {3'b000, r_b_green} - {3'b000, r_b_blue};
                end
            end
            MAX_GREEN: begin
                c_num = {2'b00, c_chroma, 1'b0} + {3'b000, r_b_blue}
                        - {3'b000, r_b_red};
            end
            MAX_BLUE: begin
                c_num = {1'b0, c_chroma, 2'b00} + {3'b000, r_b_red}
                        - {3'b000, r_b_green};
            end
            default: begin
                c_num = '0;
            end
        endcase
        // chroma * (2^N - 1)
        c_sat_dvd = {c_chroma, {COLOR_BITS{1'b0}}} - {{COLOR_BITS{1'b0}}, c_chroma};

        n_c_beat.valid  = r_b_valid;
        n_c_beat.s_rem  = c_sat_dvd[2*COLOR_BITS-1:COLOR_BITS];
        n_c_beat.s_quo  = c_sat_dvd[COLOR_BITS-1:0];
        // a black pixel divides a zero dividend by one, which gives the zero result;
        // grey pixels have a zero dividend as well
        n_c_beat.s_div  = (r_b_max == '0) ? t_chan'(1) : r_b_max;
        n_c_beat.h_rem  = c_num;
        n_c_beat.h_quo  = '0;
        n_c_beat.h_div  = (c_chroma == '0) ? t_hdiv'(1) : c_chroma6;
        n_c_beat.bright = r_b_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_beat.valid <= 1'b0;
        end else begin
            r_c_beat.valid <= n_c_beat.valid;
        end
        r_c_beat.s_rem  <= n_c_beat.s_rem;
        r_c_beat.s_quo  <= n_c_beat.s_quo;
        r_c_beat.s_div  <= n_c_beat.s_div;
        r_c_beat.h_rem  <= n_c_beat.h_rem;
        r_c_beat.h_quo  <= n_c_beat.h_quo;
        r_c_beat.h_div  <= n_c_beat.h_div;
        r_c_beat.bright <= n_c_beat.bright;
    end

    assign w_beat[0] = r_c_beat;

    for (genvar gi = 0; gi < COLOR_BITS; gi++) begin : g_div
        rthsv_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_beat[gi]),
            .o_beat  (w_beat[gi+1])
        );
    end

    assign o_valid      = w_beat[COLOR_BITS].valid;
    assign o_hue        = w_beat[COLOR_BITS].h_quo;
    assign o_saturation = w_beat[COLOR_BITS].s_quo;
    assign o_brightness = w_beat[COLOR_BITS].bright;

endmodule

// ===== tb/tb_rgb_to_hsv_pixel.sv =====
// ---------------------------------------------------------------------------
// tb_rgb_to_hsv_pixel: self-checking bench for the rgb to hsv pixel converter
// Streams directed and random pixels in bursts, predicts each hsv result
// and checks every result beat against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_rgb_to_hsv_pixel;
    import rthsv_pkg::*;

    localparam t_chan       MAXC         = '1;
    localparam int          DRAIN_CYCLES = COLOR_BITS + 8;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          SHOW_LIMIT   = 10;

    typedef struct packed {
        t_chan hue;
        t_chan sat;
        t_chan bright;
    } hsv_px_t;

    logic    i_clk;
    logic    i_rst_n      = 1'b0;
    logic    start        = 1'b0;
    logic    busy;
    t_chan   i_red        = '0;
    t_chan   i_green      = '0;
    t_chan   i_blue       = '0;
    logic    o_valid;
    t_chan   o_hue;
    t_chan   o_saturation;
    t_chan   o_brightness;

    hsv_px_t hsv_expected_q[$];
    int      fail_count   = 0;
    int      idle_cycles  = 0;
    int      burst_left   = 0;

    rgb_to_hsv_pixel u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic hsv_px_t predict_hsv(t_chan r, t_chan g, t_chan b);
        hsv_px_t     px;
        t_maxsel     sel;
        logic [31:0] top;
        logic [31:0] bot;
        logic [31:0] chroma;
        logic [31:0] num;
        top = 32'(r);
        sel = MAX_RED;
        if (32'(g) > top) begin
            top = 32'(g);
            sel = MAX_GREEN;
        end
        if (32'(b) > top) begin
            top = 32'(b);
            sel = MAX_BLUE;
        end
        bot = 32'(r);
        if (32'(g) < bot) bot = 32'(g);
        if (32'(b) < bot) bot = 32'(b);
        chroma = top - bot;
        px.bright = t_chan'(top);
        px.sat    = (top == 0) ? '0 : t_chan'((chroma * 32'(MAXC)) / top);
        px.hue    = '0;
        if (chroma != 0) begin
            case (sel)
                MAX_RED: begin
                    // negative sector wraps by one full turn
                    num = (g >= b) ? 32'(g - b) : 6 * chroma - 32'(b - g);
                end
                MAX_GREEN: num = 2 * chroma + 32'(b) - 32'(r);
                default:   num = 4 * chroma + 32'(r) - 32'(g);
            endcase
            px.hue = t_chan'((num << COLOR_BITS) / (6 * chroma));
        end
        return px;
    endfunction

    // capture accepted pixels first so a result beat always finds its entry
    always @(posedge i_clk) begin
        hsv_px_t want;
        if (i_rst_n) begin
            if (start && !busy) begin
                hsv_expected_q.push_back(predict_hsv(i_red, i_green, i_blue));
            end
            if (o_valid) begin
                if (hsv_expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT) begin
                        $display("unexpected result beat: hue=%0d sat=%0d val=%0d",
                                 o_hue, o_saturation, o_brightness);
                    end
                end else begin
                    want = hsv_expected_q.pop_front();
                    if (o_hue !== want.hue || o_saturation !== want.sat ||
                        o_brightness !== want.bright) begin
                        fail_count++;
                        if (fail_count <= SHOW_LIMIT) begin
                            $display({"mismatch: hue exp %0d got %0d, ",
                                      "sat exp %0d got %0d, val exp %0d got %0d"},
                                     want.hue, o_hue, want.sat, o_saturation,
                                     want.bright, o_brightness);
                        end
                    end
                end
            end
        end
    end

    // cycles with no beat on either side
    always @(posedge i_clk) begin
        if (i_rst_n && ((start && !busy) || o_valid)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_pixel(input t_chan r, input t_chan g, input t_chan b);
        start   <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // sender bursts: random run lengths, some long runs without gaps
    task automatic send_in_bursts(input t_chan r, input t_chan g, input t_chan b);
        send_pixel(r, g, b);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 12);
            hold_off($urandom_range(0, 9));
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (hsv_expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic make_pixel(output t_chan r, output t_chan g, output t_chan b);
        t_chan base;
        r    = t_chan'($urandom);
        g    = t_chan'($urandom);
        b    = t_chan'($urandom);
        base = t_chan'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                // grey
                g = r;
                b = r;
            end
            1: g = r;                     // red and green tie
            2: b = r;                     // red and blue tie
            3: b = g;                     // green and blue tie
            4: begin
                // chroma of a few codes
                r = base;
                g = (base > MAXC - 3) ? base - t_chan'($urandom_range(0, 3))
                                      : base + t_chan'($urandom_range(0, 3));
                b = (base < 3) ? base + t_chan'($urandom_range(0, 3))
                               : base - t_chan'($urandom_range(0, 3));
            end
            5: begin
                // dark pixels
                r = t_chan'($urandom_range(0, 15));
                g = t_chan'($urandom_range(0, 15));
                b = t_chan'($urandom_range(0, 15));
            end
            6: begin
                // saturated: one channel full, one empty
                case ($urandom_range(0, 2))
                    0:       begin r = MAXC; b = '0; end
                    1:       begin g = MAXC; r = '0; end
                    default: begin b = MAXC; g = '0; end
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic test_corner_pixels();
        send_pixel(12'd0, 12'd0, 12'd0);
        send_pixel(MAXC, MAXC, MAXC);
        send_pixel(12'd2048, 12'd2048, 12'd2048);
        send_pixel(MAXC, 12'd0, 12'd0);
        send_pixel(12'd0, MAXC, 12'd0);
        send_pixel(12'd0, 12'd0, MAXC);
        send_pixel(MAXC, MAXC, 12'd0);
        send_pixel(MAXC, 12'd0, MAXC);
        send_pixel(12'd0, MAXC, MAXC);
        hold_off(3);
        send_pixel(MAXC, 12'd0, 12'd1);
        send_pixel(MAXC, 12'd0, 12'd4094);
        send_pixel(MAXC, 12'd4094, 12'd4094);
        send_pixel(12'd1, 12'd0, 12'd0);
        send_pixel(12'd0, 12'd1, 12'd0);
        send_pixel(12'd0, 12'd0, 12'd1);
        send_pixel(12'd1, 12'd1, 12'd0);
        send_pixel(12'd4094, MAXC, 12'd0);
        send_pixel(12'd0, 12'd4094, MAXC);
        send_pixel(12'd2730, 12'd1365, 12'd4095);
        send_pixel(12'hAAA, 12'h555, 12'h0F0);
        send_pixel(12'h555, 12'hAAA, 12'hF0F);
        hold_off(1);
    endtask

    task automatic test_random_stream(input int count);
        t_chan r;
        t_chan g;
        t_chan b;
        burst_left = 0;
        repeat (count) begin
            make_pixel(r, g, b);
            send_in_bursts(r, g, b);
        end
        hold_off(1);
    endtask

    task automatic test_pause_until_empty();
        t_chan r;
        t_chan g;
        t_chan b;
        repeat (3) begin
            repeat ($urandom_range(5, 40)) begin
                make_pixel(r, g, b);
                send_pixel(r, g, b);
            end
            wait_for_results();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_pixels();
        test_random_stream(1860);
        test_pause_until_empty();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && hsv_expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
